[design/jabs_pkg.sv]
// shared types and constants for the jump arc stepper
`default_nettype none
package jabs_pkg;
  localparam int POS_W = 32;
  localparam int DUR_W = 24;
  localparam int DELTA_W = 16;
  localparam int T_W = 17;
  localparam int WIDE_W = 36;
  localparam int TICK_RATE_DEF = 60;

  localparam logic [1:0] REG_DURATION = 2'd0;
  localparam logic [1:0] REG_MID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_END_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_BUILD, ST_LERP, ST_LERP_WAIT, ST_SAT, ST_SPEED, ST_SPEED_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - WIDE_W'(1);
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction
endpackage
`default_nettype wire

[design/jabs_divider.sv]
// bit-serial restoring divider: t = (elapsed << 16) / duration, one quotient bit a cycle
`default_nettype none
module jabs_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [jabs_pkg::DUR_W-1:0] elapsed,
  input  wire logic [jabs_pkg::DUR_W-1:0] duration,
  output jabs_pkg::unit_ctl_t ctl,
  output logic [jabs_pkg::T_W-1:0] quot
);
  localparam int NUM_W = jabs_pkg::DUR_W + 16;
  localparam int CNT_W = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] num;
  logic [jabs_pkg::DUR_W:0] rem;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic done;
  logic [jabs_pkg::DUR_W:0] trial;
  logic [jabs_pkg::DUR_W:0] shifted;

  assign shifted = {rem[jabs_pkg::DUR_W-1:0], num[NUM_W-1]};
  assign trial = shifted - {1'b0, duration};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
        num <= {elapsed, 16'd0};
        rem <= '0;
      end else if (busy) begin
        if (trial[jabs_pkg::DUR_W]) begin
          rem <= shifted;
          num <= {num[NUM_W-2:0], 1'b0};
        end else begin
          rem <= trial;
          num <= {num[NUM_W-2:0], 1'b1};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = num[jabs_pkg::T_W-1:0];
  assign ctl = '{start: start, busy: busy, done: done};
endmodule
`default_nettype wire

[design/jabs_serial_mul.sv]
// shift-add multiplier, one multiplier bit a cycle, product floored by a right shift
`default_nettype none
module jabs_serial_mul #(
  parameter int A_W = 36,
  parameter int B_W = 17,
  parameter int SHIFT = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [A_W-1:0] a,
  input  wire logic [B_W-1:0] b,
  output jabs_pkg::unit_ctl_t ctl,
  output logic signed [A_W-1:0] prod
);
  localparam int P_W = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);
  logic signed [P_W-1:0] acc;
  logic signed [P_W-1:0] mcand;
  logic [B_W-1:0] mplier;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic done;
  logic signed [P_W-1:0] shr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(B_W);
        acc <= '0;
        mcand <= P_W'(a);
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign shr = acc >>> SHIFT;
  assign prod = shr[A_W-1:0];
  assign ctl = '{start: start, busy: busy, done: done};
endmodule
`default_nettype wire

[design/jump_arc_cubic_bezier_stepper_core.sv]
// top level of the jump arc stepper
// A start item latches the start point and returns nothing; a tick item returns one result,
// built in order by a bit-serial divide for t (not run when the duration is zero), a step
// to build the control points, eighteen serial lerps (six per axis) on one shared 17-bit
// shift-add multiplier, a saturation step, two serial multiplies by the tick rate and an
// output step, which waits while a previous result is still stalled. Items are handled
// one at a time; the input stalls while busy.
`default_nettype none
module jump_arc_cubic_bezier_stepper_core #(
  parameter int TICK_RATE = jabs_pkg::TICK_RATE_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic mode,
  input  wire logic [jabs_pkg::DELTA_W-1:0] delta,
  input  wire logic signed [jabs_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [jabs_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [jabs_pkg::POS_W-1:0] pos_z,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [jabs_pkg::POS_W-1:0] cfg_data,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [jabs_pkg::POS_W-1:0] cur_x,
  output logic signed [jabs_pkg::POS_W-1:0] cur_y,
  output logic signed [jabs_pkg::POS_W-1:0] cur_z,
  output logic signed [jabs_pkg::POS_W-1:0] speed_x,
  output logic signed [jabs_pkg::POS_W-1:0] speed_y,
  output logic finished
);
  localparam int W = jabs_pkg::WIDE_W;
  localparam int RATE_W = $clog2(TICK_RATE + 1);
  localparam int SW = W + RATE_W;
  localparam logic signed [SW-1:0] SPD_HI = SW'(33'sh0_7FFF_FFFF);
  localparam logic signed [SW-1:0] SPD_LO = -SPD_HI - SW'(1);

  jabs_pkg::state_t state, state_next;
  logic [jabs_pkg::DUR_W-1:0] duration;
  logic signed [jabs_pkg::POS_W-1:0] mid_h, end_h;
  logic signed [jabs_pkg::POS_W-1:0] start_x, start_y, start_z, prev_x, prev_y;
  logic [jabs_pkg::DUR_W-1:0] elapsed;
  logic signed [jabs_pkg::POS_W-1:0] tgt_x, tgt_y, tgt_z;
  logic [jabs_pkg::T_W-1:0] t;
  logic signed [W-1:0] pt [3][4];
  logic [1:0] axis;
  logic [2:0] step;
  logic signed [W-1:0] res [3];
  logic [0:0] spd;
  logic signed [jabs_pkg::POS_W-1:0] spd_r [2];

  logic in_acc;
  logic out_free;
  logic [jabs_pkg::DUR_W:0] sum;
  jabs_pkg::unit_ctl_t div_ctl, mul_ctl, rmul_ctl;
  logic [jabs_pkg::T_W-1:0] quot;
  logic signed [W-1:0] la, lb, lprod;
  logic signed [SW-1:0] rprod, rdiff;

  assign in_stall = (state != jabs_pkg::ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !(out_valid && out_stall);
  assign cfg_ready = (state == jabs_pkg::ST_IDLE);
  assign sum = {1'b0, elapsed} + (jabs_pkg::DUR_W + 1)'(delta);

  jabs_divider u_div (
    .clk(clk), .rst(rst), .start(state == jabs_pkg::ST_DIV && !div_ctl.busy && !div_ctl.done
      && duration != '0),
    .elapsed(elapsed), .duration(duration), .ctl(div_ctl), .quot(quot)
  );

  // lerp operands: level by step
  always_comb begin
    la = pt[axis][0];
    lb = pt[axis][1];
    case (step)
      3'd0: begin la = pt[axis][0]; lb = pt[axis][1]; end
      3'd1: begin la = pt[axis][1]; lb = pt[axis][2]; end
      3'd2: begin la = pt[axis][2]; lb = pt[axis][3]; end
      3'd3: begin la = pt[axis][0]; lb = pt[axis][1]; end
      3'd4: begin la = pt[axis][1]; lb = pt[axis][2]; end
      3'd5: begin la = pt[axis][0]; lb = pt[axis][1]; end
      default: ;
    endcase
  end

  jabs_serial_mul #(.A_W(W), .B_W(jabs_pkg::T_W), .SHIFT(16)) u_lerp (
    .clk(clk), .rst(rst), .start(state == jabs_pkg::ST_LERP), .a(lb - la), .b(t),
    .ctl(mul_ctl), .prod(lprod)
  );

  assign rdiff = spd[0] ? SW'(res[1]) - SW'(prev_y) : SW'(res[0]) - SW'(prev_x);

  jabs_serial_mul #(.A_W(SW), .B_W(RATE_W), .SHIFT(0)) u_rate (
    .clk(clk), .rst(rst), .start(state == jabs_pkg::ST_SPEED), .a(rdiff),
    .b(RATE_W'(TICK_RATE)), .ctl(rmul_ctl), .prod(rprod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jabs_pkg::ST_IDLE;
      duration <= jabs_pkg::DUR_W'(65536);
      mid_h <= 32'sd131072;
      end_h <= 32'sd65536;
      start_x <= '0; start_y <= '0; start_z <= '0;
      prev_x <= '0; prev_y <= '0;
      elapsed <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jabs_pkg::REG_DURATION: duration <= cfg_data[jabs_pkg::DUR_W-1:0];
          jabs_pkg::REG_MID_HEIGHT: mid_h <= cfg_data;
          jabs_pkg::REG_END_HEIGHT: end_h <= cfg_data;
          default: ;
        endcase
      end
      if (state == jabs_pkg::ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_acc) begin
        if (!mode) begin
          start_x <= pos_x; start_y <= pos_y; start_z <= pos_z;
          prev_x <= pos_x; prev_y <= pos_y;
          elapsed <= '0;
        end else begin
          elapsed <= (sum < {1'b0, duration}) ? sum[jabs_pkg::DUR_W-1:0] : duration;
        end
      end
      if (state == jabs_pkg::ST_OUT && out_free) begin
        prev_x <= res[0][jabs_pkg::POS_W-1:0];
        prev_y <= res[1][jabs_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_x <= pos_x; tgt_y <= pos_y; tgt_z <= pos_z;
      axis <= '0; step <= '0; spd <= '0;
    end
    case (state)
      jabs_pkg::ST_DIV: begin
        if (duration == '0) t <= jabs_pkg::T_W'(65536);
        else if (div_ctl.done) t <= quot;
      end
      jabs_pkg::ST_BUILD: begin
        pt[0][0] <= W'(start_x);
        pt[0][1] <= (W'(start_x) + W'(tgt_x)) >>> 1;
        pt[0][2] <= W'(tgt_x);
        pt[0][3] <= W'(tgt_x);
        pt[1][0] <= W'(start_y);
        pt[1][1] <= ((W'(start_y) + W'(tgt_y)) >>> 1) + W'(mid_h);
        pt[1][2] <= W'(tgt_y) + W'(end_h);
        pt[1][3] <= W'(tgt_y);
        pt[2][0] <= W'(start_z);
        pt[2][1] <= (W'(start_z) + W'(tgt_z)) >>> 1;
        pt[2][2] <= W'(tgt_z);
        pt[2][3] <= W'(tgt_z);
      end
      jabs_pkg::ST_LERP_WAIT: begin
        if (mul_ctl.done) begin
          case (step)
            3'd0, 3'd3, 3'd5: pt[axis][0] <= la + lprod;
            3'd1, 3'd4: pt[axis][1] <= la + lprod;
            3'd2: pt[axis][2] <= la + lprod;
            default: ;
          endcase
          if (step == 3'd5) begin
            res[axis] <= la + lprod;
            step <= '0;
            axis <= axis + 2'd1;
          end else begin
            step <= step + 3'd1;
          end
        end
      end
      jabs_pkg::ST_SAT: begin
        res[0] <= W'(jabs_pkg::sat32(res[0]));
        res[1] <= W'(jabs_pkg::sat32(res[1]));
        res[2] <= W'(jabs_pkg::sat32(res[2]));
      end
      jabs_pkg::ST_SPEED_WAIT: begin
        if (rmul_ctl.done) begin
          if (rprod > SPD_HI) spd_r[spd] <= SPD_HI[jabs_pkg::POS_W-1:0];
          else if (rprod < SPD_LO) spd_r[spd] <= SPD_LO[jabs_pkg::POS_W-1:0];
          else spd_r[spd] <= rprod[jabs_pkg::POS_W-1:0];
          spd <= spd + 1'b1;
        end
      end
      jabs_pkg::ST_OUT: begin
        if (out_free) begin
          cur_x <= res[0][jabs_pkg::POS_W-1:0];
          cur_y <= res[1][jabs_pkg::POS_W-1:0];
          cur_z <= res[2][jabs_pkg::POS_W-1:0];
          speed_x <= spd_r[0];
          speed_y <= spd_r[1];
          finished <= (elapsed == duration);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      jabs_pkg::ST_IDLE: if (in_acc && mode) state_next = jabs_pkg::ST_DIV;
      jabs_pkg::ST_DIV: if (duration == '0 || div_ctl.done) state_next = jabs_pkg::ST_BUILD;
      jabs_pkg::ST_BUILD: state_next = jabs_pkg::ST_LERP;
      jabs_pkg::ST_LERP: state_next = jabs_pkg::ST_LERP_WAIT;
      jabs_pkg::ST_LERP_WAIT: if (mul_ctl.done)
        state_next = (step == 3'd5 && axis == 2'd2) ? jabs_pkg::ST_SAT : jabs_pkg::ST_LERP;
      jabs_pkg::ST_SAT: state_next = jabs_pkg::ST_SPEED;
      jabs_pkg::ST_SPEED: state_next = jabs_pkg::ST_SPEED_WAIT;
      jabs_pkg::ST_SPEED_WAIT: if (rmul_ctl.done)
        state_next = spd[0] ? jabs_pkg::ST_OUT : jabs_pkg::ST_SPEED;
      jabs_pkg::ST_OUT: if (out_free) state_next = jabs_pkg::ST_IDLE;
      default: state_next = jabs_pkg::ST_IDLE;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cur_x)) else $error("result dropped");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != jabs_pkg::ST_IDLE |-> in_stall) else $error("input taken while busy");
  a_elapsed_cap: assert property (@(posedge clk) disable iff (rst)
    state == jabs_pkg::ST_BUILD |-> elapsed <= duration) else $error("elapsed over duration");
endmodule
`default_nettype wire

[bench/testbench.sv]
// self-checking testbench for the jump arc cubic bezier stepper
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic mode;
    logic [15:0] delta;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } jump_item_t;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic fin;
  } arc_point_t;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [15:0] delta = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] cur_x, cur_y, cur_z, speed_x, speed_y;
  logic finished;

  jump_arc_cubic_bezier_stepper_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .delta(delta), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z),
    .speed_x(speed_x), .speed_y(speed_y), .finished(finished)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state and registers
  logic [23:0] dur_reg = 24'd65536;
  logic signed [31:0] mid_lift = 32'sd131072;
  logic signed [31:0] end_lift = 32'sd65536;
  logic signed [31:0] org_x = '0, org_y = '0, org_z = '0;
  logic signed [31:0] last_x = '0, last_y = '0;
  logic [23:0] run_time = '0;

  jump_item_t pending_items[$];
  arc_point_t arc_expect[$];
  int errors = 0;

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic longint arc_eval(longint p0, longint p1, longint p2, longint p3,
                                      longint t);
    longint a, b, c, d, e;
    a = blend(p0, p1, t);
    b = blend(p1, p2, t);
    c = blend(p2, p3, t);
    d = blend(a, b, t);
    e = blend(b, c, t);
    return blend(d, e, t);
  endfunction

  function automatic longint clamp_q32(longint v);
    if (v > longint'(POS_MAX)) return longint'(POS_MAX);
    if (v < longint'(POS_MIN)) return longint'(POS_MIN);
    return v;
  endfunction

  function automatic void predict_step(jump_item_t it);
    logic [24:0] sum;
    longint t, cx, cy, cz;
    arc_point_t r;
    if (!it.mode) begin
      org_x = it.px;
      org_y = it.py;
      org_z = it.pz;
      last_x = it.px;
      last_y = it.py;
      run_time = '0;
      return;
    end
    sum = run_time + it.delta;
    run_time = (sum < {1'b0, dur_reg}) ? sum[23:0] : dur_reg;
    if (dur_reg == 0) t = 65536;
    else t = (longint'(run_time) << 16) / longint'(dur_reg);
    cx = arc_eval(longint'(org_x), (longint'(org_x) + longint'(it.px)) >>> 1,
                  longint'(it.px), longint'(it.px), t);
    cy = arc_eval(longint'(org_y),
                  ((longint'(org_y) + longint'(it.py)) >>> 1) + longint'(mid_lift),
                  longint'(it.py) + longint'(end_lift), longint'(it.py), t);
    cz = arc_eval(longint'(org_z), (longint'(org_z) + longint'(it.pz)) >>> 1,
                  longint'(it.pz), longint'(it.pz), t);
    cx = clamp_q32(cx);
    cy = clamp_q32(cy);
    cz = clamp_q32(cz);
    r.cx = cx[31:0];
    r.cy = cy[31:0];
    r.cz = cz[31:0];
    r.sx = 32'(clamp_q32((cx - longint'(last_x)) * jabs_pkg::TICK_RATE_DEF));
    r.sy = 32'(clamp_q32((cy - longint'(last_y)) * jabs_pkg::TICK_RATE_DEF));
    r.fin = (run_time == dur_reg);
    last_x = cx[31:0];
    last_y = cy[31:0];
    arc_expect.push_back(r);
  endfunction

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_step('{mode, delta, pos_x, pos_y, pos_z});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          jump_item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          mode <= it.mode;
          delta <= it.delta;
          pos_x <= it.px;
          pos_y <= it.py;
          pos_z <= it.pz;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (arc_expect.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          arc_point_t e;
          e = arc_expect.pop_front();
          if (cur_x !== e.cx) begin
            $error("cur_x expected %0d got %0d", e.cx, cur_x); errors++;
          end
          if (cur_y !== e.cy) begin
            $error("cur_y expected %0d got %0d", e.cy, cur_y); errors++;
          end
          if (cur_z !== e.cz) begin
            $error("cur_z expected %0d got %0d", e.cz, cur_z); errors++;
          end
          if (speed_x !== e.sx) begin
            $error("speed_x expected %0d got %0d", e.sx, speed_x); errors++;
          end
          if (speed_y !== e.sy) begin
            $error("speed_y expected %0d got %0d", e.sy, speed_y); errors++;
          end
          if (finished !== e.fin) begin
            $error("finished expected %0d got %0d", e.fin, finished); errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 37;
      if (stall_phase < 12) out_stall <= 1'b0;
      else if (stall_phase < 20) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic add_item(logic m, logic [15:0] d, logic signed [31:0] x,
                          logic signed [31:0] y, logic signed [31:0] z);
    jump_item_t it;
    it = '{m, d, x, y, z};
    pending_items.push_back(it);
  endtask

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
      2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      3: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      default: return '0;
    endcase
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || arc_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      jabs_pkg::REG_DURATION: dur_reg = val[23:0];
      jabs_pkg::REG_MID_HEIGHT: mid_lift = val;
      jabs_pkg::REG_END_HEIGHT: end_lift = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [23:0] d, logic signed [31:0] m, logic signed [31:0] e);
    drain();
    write_reg(jabs_pkg::REG_DURATION, {8'd0, d});
    write_reg(jabs_pkg::REG_MID_HEIGHT, m);
    write_reg(jabs_pkg::REG_END_HEIGHT, e);
  endtask

  task automatic random_phase(int count);
    int n, k;
    logic signed [31:0] tx, ty, tz;
    longint span;
    while (count > 0) begin
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(1, 10);
        add_item(1'b0, 16'($urandom()), rand_pos(), rand_pos(), rand_pos());
        tx = rand_pos(); ty = rand_pos(); tz = rand_pos();
        span = (longint'(dur_reg) * 2) / n + 1;
        if (span > 65535) span = 65535;
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            tx = rand_pos(); ty = rand_pos(); tz = rand_pos();
          end
          add_item(1'b1, ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                   : 16'($urandom_range(0, int'(span))),
                   tx, ty, tz);
        end
        count -= n + 1;
      end else begin
        add_item(1'($urandom()), 16'($urandom()), $urandom(), $urandom(), $urandom());
        count--;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, reset registers
    add_item(1'b1, 16'd1000, 32'sd65536, 32'sd65536, -32'sd65536);
    add_item(1'b0, 16'd0, '0, '0, '0);
    add_item(1'b1, 16'd0, 32'sd655360, 32'sd0, 32'sd327680);
    add_item(1'b1, 16'd32768, 32'sd655360, 32'sd0, 32'sd327680);
    add_item(1'b1, 16'hFFFF, 32'sd655360, 32'sd0, 32'sd327680);
    add_item(1'b1, 16'd5, 32'sd655360, 32'sd0, 32'sd327680);
    add_item(1'b0, 16'hFFFF, POS_MAX, POS_MAX, POS_MAX);
    add_item(1'b1, 16'd20000, POS_MIN, POS_MIN, POS_MIN);
    add_item(1'b1, 16'd20000, POS_MAX, POS_MAX, POS_MAX);
    add_item(1'b0, 16'd0, POS_MIN, POS_MIN, POS_MIN);
    add_item(1'b1, 16'd40000, POS_MAX, POS_MAX, POS_MAX);
    add_item(1'b1, 16'hFFFF, POS_MAX, POS_MAX, POS_MAX);
    add_item(1'b0, 16'd0, 32'sd1, -32'sd1, 32'sd1);
    add_item(1'b1, 16'd1, -32'sd1, 32'sd1, -32'sd1);
    set_regs(24'd1, POS_MAX, POS_MIN);
    add_item(1'b1, 16'd0, 32'sd100, 32'sd100, 32'sd100);
    add_item(1'b1, 16'd1, POS_MAX, POS_MIN, POS_MAX);
    add_item(1'b0, 16'd0, POS_MAX, POS_MIN, 32'sd0);
    add_item(1'b1, 16'd0, POS_MIN, POS_MAX, 32'sd0);
    set_regs(24'hFFFFFF, POS_MIN, POS_MAX);
    add_item(1'b0, 16'd0, POS_MIN, POS_MAX, POS_MIN);
    add_item(1'b1, 16'hFFFF, POS_MAX, POS_MIN, POS_MAX);
    add_item(1'b1, 16'hFFFF, POS_MAX, POS_MIN, POS_MAX);
    random_phase(200);
    // duration lowered below elapsed, then zero duration
    set_regs(24'd100, 32'sd131072, 32'sd65536);
    add_item(1'b1, 16'd0, 32'sd65536, 32'sd65536, 32'sd65536);
    random_phase(120);
    set_regs(24'd0, $urandom(), $urandom());
    add_item(1'b1, 16'd0, POS_MAX, POS_MAX, POS_MIN);
    random_phase(120);
    set_regs(24'd1, $urandom(), $urandom());
    random_phase(150);
    repeat (6) begin
      set_regs(($urandom_range(0, 1) != 0) ? 24'($urandom_range(1, 300000))
                                           : 24'($urandom_range(1, 2000)),
               ($urandom_range(0, 1) != 0) ? 32'($urandom())
                                           : 32'($urandom_range(0, 1 << 20)),
               ($urandom_range(0, 1) != 0) ? 32'($urandom())
                                           : 32'($urandom_range(0, 1 << 20)));
      random_phase(230);
    end

    drain();
    if (errors == 0 && arc_expect.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
design/jabs_pkg.sv
design/jabs_divider.sv
design/jabs_serial_mul.sv
design/jump_arc_cubic_bezier_stepper_core.sv
bench/testbench.sv
